[src/fbm_pkg.sv]
// Package for the fractal value-noise density block: widths, hash constants,
// register addresses and small helper functions. No dependencies.
package fbm_pkg;

  localparam logic [31:0] HashX = 32'h8da6b343;
  localparam logic [31:0] HashY = 32'hd8163841;
  localparam logic [31:0] HashZ = 32'hcb1ab31f;
  localparam logic [31:0] HashM1 = 32'h2c1b3c6d;
  localparam logic [31:0] HashM2 = 32'h297a2d39;

  localparam int CfgAddrW = 5;
  localparam logic [CfgAddrW-1:0] RegOctaves = 5'd0;
  localparam logic [CfgAddrW-1:0] RegFreq    = 5'd4;
  localparam logic [CfgAddrW-1:0] RegWindX   = 5'd8;
  localparam logic [CfgAddrW-1:0] RegWindY   = 5'd12;
  localparam logic [CfgAddrW-1:0] RegWindZ   = 5'd16;
  localparam logic [CfgAddrW-1:0] RegStrength = 5'd20;

  // First avalanche step of the lattice hash, applied to the corner sum.
  function automatic logic [31:0] hash_mix_a(input logic [31:0] h);
    logic [31:0] v;
    v = h ^ (h >> 15);
    return v * HashM1;
  endfunction

  function automatic logic [31:0] hash_mix_b(input logic [31:0] h);
    logic [31:0] v;
    v = h ^ (h >> 12);
    v = v * HashM2;
    return v ^ (v >> 15);
  endfunction

endpackage

[src/fbm_octave.sv]
// One octave of trilinear value noise as a pipeline of registered stages.
// Depends on fbm_pkg for the hash constants and mixing functions.
module fbm_octave import fbm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic [FRAC_BITS+31:0]  px,
  input  logic [FRAC_BITS+31:0]  py,
  input  logic [FRAC_BITS+31:0]  pz,
  output logic [23:0]            noise
);
  localparam int F = FRAC_BITS;

  // Stage 1: corner hash partial products and fade first square.
  logic [31:0] ix, iy, iz;
  logic [F-1:0] tx, ty, tz;
  assign ix = px[F+31:F];
  assign iy = py[F+31:F];
  assign iz = pz[F+31:F];
  assign tx = px[F-1:0];
  assign ty = py[F-1:0];
  assign tz = pz[F-1:0];

  logic [31:0] hx0, hx1, hy0, hy1, hz0, hz1;
  logic [F-1:0] t2x, t2y, t2z, tx1, ty1, tz1;
  always_ff @(posedge clk) begin
    hx0 <= ix * HashX;
    hx1 <= (ix + 32'd1) * HashX;
    hy0 <= iy * HashY;
    hy1 <= (iy + 32'd1) * HashY;
    hz0 <= iz * HashZ;
    hz1 <= (iz + 32'd1) * HashZ;
    t2x <= F'(({{F{1'b0}}, tx} * {{F{1'b0}}, tx}) >> F);
    t2y <= F'(({{F{1'b0}}, ty} * {{F{1'b0}}, ty}) >> F);
    t2z <= F'(({{F{1'b0}}, tz} * {{F{1'b0}}, tz}) >> F);
    tx1 <= tx;
    ty1 <= ty;
    tz1 <= tz;
  end

  // Stage 2: first mix multiply, fade second product.
  logic [31:0] ha [8];
  logic [F:0] ux, uy, uz;
  function automatic logic [F:0] fade2(input logic [F-1:0] t2, input logic [F-1:0] t);
    logic [F+1:0] k;
    logic [2*F+2:0] p;
    k = (F+2)'(3) << F;
    k = k - ({2'b0, t} << 1);
    p = {{(F+3){1'b0}}, t2} * {{(F+1){1'b0}}, k};
    return (F+1)'(p >> F);
  endfunction
  always_ff @(posedge clk) begin
    for (int c = 0; c < 8; c++) begin
      ha[c] <= hash_mix_a((c[0] ? hx1 : hx0) + (c[1] ? hy1 : hy0) + (c[2] ? hz1 : hz0));
    end
    ux <= fade2(t2x, tx1);
    uy <= fade2(t2y, ty1);
    uz <= fade2(t2z, tz1);
  end

  // Stage 3: second hash multiply, corner values.
  logic [23:0] cv [8];
  logic [F:0] ux3, uy3, uz3;
  always_ff @(posedge clk) begin
    for (int c = 0; c < 8; c++) cv[c] <= 24'(hash_mix_b(ha[c]) >> 8);
    ux3 <= ux;
    uy3 <= uy;
    uz3 <= uz;
  end

  function automatic logic [23:0] lerp(input logic [23:0] a, input logic [23:0] b,
                                       input logic [F:0] u);
    logic signed [24:0] d;
    logic signed [F+26:0] p;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, u});
    return a + 24'(p >>> F);
  endfunction

  // Stages 4 to 6: interpolate along x, then y, then z.
  logic [23:0] lx [4];
  logic [F:0] uy4, uz4, uz5;
  logic [23:0] ly [2];
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) lx[c] <= lerp(cv[2*c], cv[2*c+1], ux3);
    uy4 <= uy3;
    uz4 <= uz3;
    ly[0] <= lerp(lx[0], lx[1], uy4);
    ly[1] <= lerp(lx[2], lx[3], uy4);
    uz5 <= uz4;
    noise <= lerp(ly[0], ly[1], uz5);
  end
endmodule

[src/fbm_coord.sv]
// Coordinate generator: position times frequency plus wind times time.
// Depends on fbm_pkg only through the import convention.
module fbm_coord import fbm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic [31:0]           pos,
  input  logic [31:0]           wind,
  input  logic [31:0]           tnow,
  input  logic [23:0]           freq,
  output logic [FRAC_BITS+31:0] coord
);
  logic signed [63:0] a, b;
  always_ff @(posedge clk) begin
    a <= $signed(pos) * $signed({1'b0, freq});
    b <= $signed(wind) * $signed({1'b0, tnow});
    coord <= (FRAC_BITS+32)'(a >>> (32 - FRAC_BITS)) + (FRAC_BITS+32)'(b >>> (32 - FRAC_BITS));
  end
endmodule

[src/fbm_value_noise_density_top.sv]
// Fractal value-noise density: a fully pipelined datapath taking one beat per cycle.
// Throughput is one beat every cycle, as busy is held low. The octave units are
// chained, each doubling the coordinate as it passes. rst is synchronous and
// clears the valid pipe and loads register reset values; the receiver cannot
// stall, so results are never held.
module fbm_value_noise_density_top import fbm_pkg::*; #(
  parameter int MAX_OCTAVES = 5,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [31:0]         pos_x,
  input  logic [31:0]         pos_y,
  input  logic [31:0]         pos_z,
  input  logic [31:0]         time_now,
  output logic                done,
  output logic [15:0]         density,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int F = FRAC_BITS;
  localparam int CW = F + 32;
  localparam int OL = 6;                        // octave unit latency
  localparam int LAT = 3 + OL * MAX_OCTAVES + 4;
  localparam logic [CW-1:0] OffX = CW'(((64'd1919 << F) + 64'd50) / 64'd100);
  localparam logic [CW-1:0] OffY = CW'(((64'd4777 << F) + 64'd50) / 64'd100);
  localparam logic [CW-1:0] OffZ = CW'(((64'd7413 << F) + 64'd50) / 64'd100);

  // Reciprocals round(2^32/(2^k-1)) for each octave count k.
  localparam logic [32:0] Rec1 = 33'((64'd1 << 32) / 64'd1);
  localparam logic [32:0] Rec2 = 33'(((64'd1 << 32) + 64'd1) / 64'd3);
  localparam logic [32:0] Rec3 = 33'(((64'd1 << 32) + 64'd3) / 64'd7);
  localparam logic [32:0] Rec4 = 33'(((64'd1 << 32) + 64'd7) / 64'd15);
  localparam logic [32:0] Rec5 = 33'(((64'd1 << 32) + 64'd15) / 64'd31);
  localparam logic [32:0] Rec6 = 33'(((64'd1 << 32) + 64'd31) / 64'd63);
  localparam logic [32:0] Rec7 = 33'(((64'd1 << 32) + 64'd63) / 64'd127);

  // Configuration registers.
  logic [2:0]  octave_count;
  logic [23:0] frequency_scale;
  logic [31:0] wind_x, wind_y, wind_z;
  logic [15:0] strength;
  logic        wr;
  assign pready = 1'b1;
  assign busy = 1'b0;
  assign wr = psel & penable & pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 3'd4;
      frequency_scale <= 24'd65536;
      wind_x <= '0;
      wind_y <= '0;
      wind_z <= '0;
      strength <= 16'd4096;
    end else if (wr) begin
      unique case (paddr)
        RegOctaves:  octave_count <= pwdata[2:0];
        RegFreq:     frequency_scale <= pwdata[23:0];
        RegWindX:    wind_x <= pwdata;
        RegWindY:    wind_y <= pwdata;
        RegWindZ:    wind_z <= pwdata;
        RegStrength: strength <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      RegOctaves:  prdata = {29'd0, octave_count};
      RegFreq:     prdata = {8'd0, frequency_scale};
      RegWindX:    prdata = wind_x;
      RegWindY:    prdata = wind_y;
      RegWindZ:    prdata = wind_z;
      RegStrength: prdata = {16'd0, strength};
      default:     prdata = '0;
    endcase
  end

  // Valid bits travel alongside the data.
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], start};
  end
  assign done = vld[LAT-1];

  // Coordinate stages (the fbm_coord product and sum registers, then the octave unit input register).
  logic [CW-1:0] cx, cy, cz;
  fbm_coord #(.FRAC_BITS(F)) u_cx (.clk, .pos(pos_x), .wind(wind_x), .tnow(time_now),
    .freq(frequency_scale), .coord(cx));
  fbm_coord #(.FRAC_BITS(F)) u_cy (.clk, .pos(pos_y), .wind(wind_y), .tnow(time_now),
    .freq(frequency_scale), .coord(cy));
  fbm_coord #(.FRAC_BITS(F)) u_cz (.clk, .pos(pos_z), .wind(wind_z), .tnow(time_now),
    .freq(frequency_scale), .coord(cz));

  // Octave chain. Each octave's input coordinate is registered once, then it is
  // delayed beside the unit and, doubled plus an offset, feeds the next octave.
  logic [CW-1:0] ox [MAX_OCTAVES], oy [MAX_OCTAVES], oz [MAX_OCTAVES];
  logic [23:0]   on [MAX_OCTAVES];
  logic [CW-1:0] dx [MAX_OCTAVES][OL-1], dy [MAX_OCTAVES][OL-1], dz [MAX_OCTAVES][OL-1];
  logic [23+MAX_OCTAVES:0] acc [MAX_OCTAVES+1];
  logic [2:0] kc;
  assign kc = (octave_count == 3'd0) ? 3'd1 :
              (32'(octave_count) > MAX_OCTAVES) ? 3'(MAX_OCTAVES) : octave_count;

  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
    if (o == 0) begin : g_first
      always_ff @(posedge clk) begin
        ox[0] <= cx;
        oy[0] <= cy;
        oz[0] <= cz;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        ox[o] <= (dx[o-1][OL-2] << 1) + OffX;
        oy[o] <= (dy[o-1][OL-2] << 1) + OffY;
        oz[o] <= (dz[o-1][OL-2] << 1) + OffZ;
      end
    end
    // Coordinate delay line running beside the octave unit.
    always_ff @(posedge clk) begin
      dx[o][0] <= ox[o];
      dy[o][0] <= oy[o];
      dz[o][0] <= oz[o];
      for (int s = 1; s < OL - 1; s++) begin
        dx[o][s] <= dx[o][s-1];
        dy[o][s] <= dy[o][s-1];
        dz[o][s] <= dz[o][s-1];
      end
    end
    fbm_octave #(.FRAC_BITS(F)) u_oct (.clk, .px(ox[o]), .py(oy[o]), .pz(oz[o]),
      .noise(on[o]));
  end

  // Octave noise values land at staggered times; each is held in a delay so
  // the accumulation happens once all are present.
  logic [23:0] nd [MAX_OCTAVES][OL*MAX_OCTAVES];
  logic [23:0] nal [MAX_OCTAVES];
  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_al
    localparam int D = OL * (MAX_OCTAVES - 1 - o);
    if (D == 0) begin : g_nd
      assign nal[o] = on[o];
    end else begin : g_d
      always_ff @(posedge clk) begin
        nd[o][0] <= on[o];
        for (int s = 1; s < D; s++) nd[o][s] <= nd[o][s-1];
      end
      assign nal[o] = nd[o][D-1];
    end
  end

  // Keep configuration static while items flow (not enforced by the block); kc is used directly.
  always_comb begin
    acc[0] = '0;
    for (int o = 0; o < MAX_OCTAVES; o++) begin
      acc[o+1] = (32'(o) < 32'(kc)) ? ((acc[o] << 1) + (24+MAX_OCTAVES)'(nal[o])) : acc[o];
    end
  end

  // Normalise by round(2^32/(2^k-1)), taken from a small table.
  logic [23+MAX_OCTAVES:0] wsum;
  logic [32:0] rec;
  logic [63:0] prod;
  logic [24:0] nrm;
  logic signed [42:0] sp;
  logic signed [20:0] sv;
  logic signed [21:0] m;
  always_ff @(posedge clk) begin
    wsum <= acc[MAX_OCTAVES];
    case (kc)
      3'd1:    rec <= Rec1;
      3'd2:    rec <= Rec2;
      3'd3:    rec <= Rec3;
      3'd4:    rec <= Rec4;
      3'd5:    rec <= Rec5;
      3'd6:    rec <= Rec6;
      3'd7:    rec <= Rec7;
      default: rec <= Rec1;
    endcase
  end
  always_ff @(posedge clk) begin
    prod <= 64'(wsum) * 64'(rec);
  end
  always_comb begin
    nrm = 25'((prod + (64'd1 << 31)) >> 32);
    sp = $signed({17'd0, nrm, 1'b0}) - $signed(43'd1 << 24);
  end
  logic signed [60:0] sm;
  always_ff @(posedge clk) begin
    sm <= sp * $signed({1'b0, strength});
  end
  always_comb begin
    sv = 21'((sm + 61'sd2097152) >>> 22);
    m = 22'sd16384 + 22'(sv);
  end
  always_ff @(posedge clk) begin
    if (m < 0) density <= 16'd0;
    else if (m > 22'sd32768) density <= 16'd32768;
    else density <= 16'(m);
  end
endmodule

[src/fbm_checker.sv]
// Port-level checker for the density block, bound to the top level.
// Imports fbm_pkg but uses nothing from it.
module fbm_checker import fbm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [15:0] density,
  input logic pready
);
  a_range: assert property (@(posedge clk) disable iff (rst) done |-> density <= 16'd32768)
    else $error("density above two");
  a_nobusy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_idle: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result straight after reset");
endmodule

bind fbm_value_noise_density_top fbm_checker u_chk (.clk, .rst, .start, .busy, .done,
  .density, .pready);

[tb/testbench.sv]
// Self-checking testbench for fbm_value_noise_density_top. It holds its own
// predictor and a scoreboard class, and depends only on fbm_pkg and the top level.
`timescale 1ns / 100ps

module testbench import fbm_pkg::*;;

  // An address that decodes to no register, so writes to it must be ignored.
  localparam logic [CfgAddrW-1:0] RegUnused = 5'd24;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 60;

  // The octave offsets 19.19, 47.77 and 74.13, rounded to nearest in Q16.16.
  localparam longint OffX = ((longint'(1919) << 16) + 50) / 100;
  localparam longint OffY = ((longint'(4777) << 16) + 50) / 100;
  localparam longint OffZ = ((longint'(7413) << 16) + 50) / 100;

  // The scoreboard keeps a copy of the register file, works out the density
  // that each accepted beat should give, and checks results in order.
  class density_scoreboard;
    logic [2:0] octaves;
    logic [23:0] freq;
    logic [31:0] wind_x, wind_y, wind_z;
    logic [15:0] strength;
    logic [15:0] expected_q[$];
    int errors;
    int checked;

    function new();
      octaves = 3'd4;
      freq = 24'd65536;
      wind_x = '0;
      wind_y = '0;
      wind_z = '0;
      strength = 16'd4096;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] addr, logic [31:0] v);
      case (addr)
        RegOctaves: octaves = v[2:0];
        RegFreq: freq = v[23:0];
        RegWindX: wind_x = v;
        RegWindY: wind_y = v;
        RegWindZ: wind_z = v;
        RegStrength: strength = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] corner_value(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [31:0] h;
      h = x * HashX + y * HashY + z * HashZ;
      h = h ^ (h >> 15);
      h = h * HashM1;
      h = h ^ (h >> 12);
      h = h * HashM2;
      h = h ^ (h >> 15);
      return h >> 8;
    endfunction

    function longint smooth(longint t);
      longint t2;
      t2 = (t * t) >>> 16;
      return (t2 * ((longint'(3) << 16) - 2 * t)) >>> 16;
    endfunction

    function logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint u);
      longint d;
      d = longint'({32'b0, b}) - longint'({32'b0, a});
      return a + 32'((d * u) >>> 16);
    endfunction

    function logic [31:0] cell_value(longint px, longint py, longint pz);
      logic [31:0] ix, iy, iz, jx, jy, jz, x00, x10, x01, x11;
      longint ux, uy, uz;
      ix = 32'(px >>> 16);
      iy = 32'(py >>> 16);
      iz = 32'(pz >>> 16);
      jx = ix + 1;
      jy = iy + 1;
      jz = iz + 1;
      ux = smooth(px & 64'hFFFF);
      uy = smooth(py & 64'hFFFF);
      uz = smooth(pz & 64'hFFFF);
      x00 = blend(corner_value(ix, iy, iz), corner_value(jx, iy, iz), ux);
      x10 = blend(corner_value(ix, jy, iz), corner_value(jx, jy, iz), ux);
      x01 = blend(corner_value(ix, iy, jz), corner_value(jx, iy, jz), ux);
      x11 = blend(corner_value(ix, jy, jz), corner_value(jx, jy, jz), ux);
      return blend(blend(x00, x10, uy), blend(x01, x11, uy), uz);
    endfunction

    function longint coord(logic [31:0] pos, logic [31:0] wind, logic [31:0] t);
      longint a, b;
      a = longint'($signed(pos)) * longint'({40'b0, freq});
      b = longint'($signed(wind)) * longint'({32'b0, t});
      return (a >>> 16) + (b >>> 16);
    endfunction

    function logic [15:0] predict_density(logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic [31:0] t);
      int k;
      longint px, py, pz, w, tot, rec, n, prod, s, m;
      k = octaves;
      if (k < 1) k = 1;
      if (k > 5) k = 5;
      px = coord(x, wind_x, t);
      py = coord(y, wind_y, t);
      pz = coord(z, wind_z, t);
      w = 0;
      for (int o = 0; o < k; o++) begin
        w = (w << 1) + longint'({32'b0, cell_value(px, py, pz)});
        px = px * 2 + OffX;
        py = py * 2 + OffY;
        pz = pz * 2 + OffZ;
      end
      tot = (longint'(1) << k) - 1;
      rec = ((longint'(1) << 32) + (tot >> 1)) / tot;
      n = (w * rec + (longint'(1) << 31)) >> 32;
      prod = (2 * n - (longint'(1) << 24)) * longint'({48'b0, strength});
      s = (prod + (longint'(1) << 21)) >>> 22;
      m = 16384 + s;
      if (m < 0) m = 0;
      if (m > 32768) m = 32768;
      return 16'(m);
    endfunction

    function void note_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] t);
      expected_q.push_back(predict_density(x, y, z, t));
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_density(logic [15:0] d);
      logic [15:0] want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("density %0d arrived with nothing expected", d));
      end else begin
        want = expected_q.pop_front();
        if (d !== want) report($sformatf("density got %0d, expected %0d", d, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [31:0] pos_x, pos_y, pos_z, time_now;
  logic done;
  logic [15:0] density;
  logic psel, penable, pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  density_scoreboard sb;
  int cycles;
  int beats;

  fbm_value_noise_density_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .time_now(time_now),
    .done(done), .density(density),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every result is held for exactly one cycle, so it is taken at the edge
  // that closes the cycle in which done is seen high.
  always @(posedge clk) begin
    if (!rst && done) sb.check_density(density);
  end

  // Watchdog: hitting CycleLimit means the block has hung or lost results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.expected_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Sends one beat. A random idle gap may come first; with no gap, start
  // simply stays high from the previous beat.
  task send_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] t);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    time_now <= t;
    do @(posedge clk); while (busy);
    sb.note_beat(x, y, z, t);
    beats++;
  endtask

  // Lowers start and waits until the pipeline has emptied, so that the
  // registers can be changed without affecting a beat in flight.
  task drain;
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // A setup phase, an access phase, then an idle phase before the next write.
  task write_reg(logic [CfgAddrW-1:0] addr, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(addr, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task write_all(logic [31:0] oct, logic [31:0] fr, logic [31:0] wx,
                 logic [31:0] wy, logic [31:0] wz, logic [31:0] st);
    write_reg(RegOctaves, oct);
    write_reg(RegFreq, fr);
    write_reg(RegWindX, wx);
    write_reg(RegWindY, wy);
    write_reg(RegWindZ, wz);
    write_reg(RegStrength, st);
    @(posedge clk);
  endtask

  // Half of the positions are near the origin, where neighbouring lattice cells
  // are visited, with some fully random words and some at the very extremes.
  function logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 255)
                                     : 32'h80000000 + $urandom_range(0, 255);
      default: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    endcase
  endfunction

  function logic [31:0] rand_time();
    return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h000fffff);
  endfunction

  task random_beats(int count);
    for (int i = 0; i < count; i++) send_beat(rand_pos(), rand_pos(), rand_pos(), rand_time());
  endtask

  initial begin
    sb = new();
    cycles = 0;
    beats = 0;
    rst = 1'b1;
    start = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    time_now = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first with the reset register values: the origin, the
    // field extremes and the largest time, where the coordinates wrap.
    send_beat(32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
    send_beat(32'h80000000, 32'h80000000, 32'h80000000, 32'h0);
    send_beat(32'hffffffff, 32'h00000001, 32'h0000ffff, 32'h00010000);
    send_beat(32'h00008000, 32'hffff8000, 32'h00018000, 32'h00000001);
    drain();

    // Huge wind with maximum frequency, so that the 48-bit coordinate and
    // the 32-bit lattice integers both wrap; full strength, five octaves.
    write_all(32'd5, 32'h00ffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0000ffff);
    send_beat(32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff);
    send_beat(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'hffffffff);
    send_beat(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h80000000);
    drain();

    // An octave count of zero is treated as one, and anything above five as
    // five; zero frequency and zero strength pin the output to 1.0.
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_beat(32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff);
    send_beat(32'h00010000, 32'h00020000, 32'h00030000, 32'h0);
    drain();
    write_reg(RegOctaves, 32'd7);
    write_reg(RegStrength, 32'h0000ffff);
    write_reg(RegFreq, 32'h00010000);
    send_beat(32'h00010000, 32'h00020000, 32'h00030000, 32'h0);
    send_beat(32'hfffeffff, 32'h0001ffff, 32'h80000001, 32'h0);
    drain();

    // A write to an undecoded address must leave every register alone, and
    // upper data bits beyond each register's width are dropped.
    write_reg(RegUnused, 32'hffffffff);
    write_reg(RegOctaves, 32'hfffffff9);
    write_reg(RegFreq, 32'hff020000);
    write_reg(RegStrength, 32'hffff1000);
    send_beat(32'h00054321, 32'hfff12345, 32'h00000000, 32'h00001000);
    send_beat(32'h00000000, 32'h00000000, 32'h00000000, 32'hffffffff);
    drain();

    // Random part in phases: each phase draws a fresh register setting.
    for (int ph = 0; ph < 8; ph++) begin
      write_all($urandom, (ph == 0) ? 32'h00ffffff : $urandom,
                (ph < 4) ? 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff) : $urandom,
                (ph < 4) ? 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff) : $urandom,
                (ph < 4) ? 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff) : $urandom,
                (ph == 1) ? 32'h0000ffff : $urandom);
      random_beats(160);
      drain();
    end

    $display("Run covered %0d beats over thirteen register settings, %0d results checked.",
             beats, sb.checked);
    $display("Mismatches counted: %0d.", sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
